>>> rtl/rpvg_pkg.sv
`timescale 1ns / 1ps
package rpvg_pkg;
	localparam int MAX_SIDES_DEF    = 64;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam logic signed [33:0] INV_GAIN = 34'sd652032875;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic [15:0] radius;
		logic [8:0]  sides;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [15:0] start;
		logic [31:0] step;
	} job_t;
endpackage

>>> rtl/rpvg_front.sv
`timescale 1ns / 1ps
// Accepts requests, clamps the side count and works out the angle step by
// restoring division of 2^32 by the side count, one quotient bit a cycle.
module rpvg_front #(
	parameter int MAX_SIDES = rpvg_pkg::MAX_SIDES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] radius_len,
	input  logic [6:0]  side_count,
	input  logic signed [15:0] centre_x,
	input  logic signed [15:0] centre_y,
	input  logic [15:0] start_angle,
	output logic q_valid,
	input  logic q_ready,
	output rpvg_pkg::job_t q_job
);
	import rpvg_pkg::*;
	typedef enum logic [1:0] {F_IDLE, F_DIV, F_OUT} fst_t;
	fst_t st_q;
	job_t job_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic [8:0] sides_c;
	logic [33:0] trial;

	always_comb begin
		if (32'(side_count) > 32'(MAX_SIDES)) sides_c = 9'(MAX_SIDES);
		else sides_c = 9'(side_count);
	end
	// dividend is 2^32: its only set bit enters at the first step
	assign trial = {rem_q, (cnt_q == 6'd0)} - {25'd0, job_q.sides};
	assign in_ready = (st_q == F_IDLE);
	assign q_valid = (st_q == F_OUT);
	assign q_job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			rem_q <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: if (in_valid) begin
					job_q.radius <= radius_len;
					job_q.sides <= sides_c;
					job_q.cx <= centre_x;
					job_q.cy <= centre_y;
					job_q.start <= start_angle;
					job_q.step <= '0;
					rem_q <= '0;
					cnt_q <= '0;
					if (sides_c == 9'd0) st_q <= F_IDLE;
					else st_q <= F_DIV;
				end
				F_DIV: begin
					if (!trial[33]) begin
						rem_q <= trial[32:0];
						job_q.step <= {job_q.step[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], (cnt_q == 6'd0)};
						job_q.step <= {job_q.step[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) st_q <= F_OUT;
				end
				F_OUT: if (q_ready) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/rpvg_back.sv
`timescale 1ns / 1ps
// Walks the vertices of one job: CORDIC one iteration a cycle, then the
// radius multiply, then round, add centre and saturate into the output register.
module rpvg_back #(
	parameter int CORDIC_STEPS = rpvg_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic j_valid,
	output logic j_ready,
	input  rpvg_pkg::job_t j_job,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] vertex_x,
	output logic signed [15:0] vertex_y,
	output logic [5:0] vertex_index,
	output logic last_vertex
);
	import rpvg_pkg::*;
	localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	typedef enum logic [2:0] {B_IDLE, B_LOAD, B_ROT, B_MUL, B_SUM, B_OUT} bst_t;
	bst_t st_q;
	job_t job_q;
	logic [31:0] acc_q;
	logic [8:0] k_q;
	logic [4:0] it_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic flip_q;
	logic signed [50:0] px_q, py_q;
	logic signed [33:0] xs, ys, za;
	logic signed [33:0] z0;
	logic big;
	logic signed [21:0] rx, ry;
	logic signed [22:0] sx, sy;

	assign z0 = {{2{acc_q[31]}}, acc_q[31:16], 16'd0};
	assign big = (z0 > 34'sh040000000) || (z0 < -34'sh040000000);
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign za = $signed({2'b00, atan_turn(it_q)});
	assign rx = 22'(px_q >>> 30);
	assign ry = 22'(py_q >>> 30);
	assign sx = 23'(rx) + 23'(job_q.cx);
	assign sy = 23'(ry) + 23'(job_q.cy);
	assign j_ready = (st_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: if (j_valid) begin
					job_q <= j_job;
					acc_q <= {j_job.start, 16'd0};
					k_q <= '0;
					st_q <= B_LOAD;
				end
				B_LOAD: begin
					// load angle, fold to the right half plane
					it_q <= '0;
					x_q <= INV_GAIN;
					y_q <= '0;
					flip_q <= big;
					z_q <= big ? {{2{~acc_q[31]}}, ~acc_q[31], acc_q[30:16], 16'd0} : z0;
					st_q <= B_ROT;
				end
				B_ROT: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - za;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + za;
					end
					it_q <= it_q + 5'd1;
					if (32'(it_q) == NSTEP - 1) st_q <= B_MUL;
				end
				B_MUL: begin
					px_q <= $signed({1'b0, job_q.radius}) * (flip_q ? -x_q : x_q)
						+ 51'sd536870912;
					py_q <= $signed({1'b0, job_q.radius}) * (flip_q ? -y_q : y_q)
						+ 51'sd536870912;
					st_q <= B_SUM;
				end
				B_SUM: begin
					vertex_x <= (sx > 23'sd32767) ? 16'sh7fff :
						(sx < -23'sd32768) ? 16'sh8000 : sx[15:0];
					vertex_y <= (sy > 23'sd32767) ? 16'sh7fff :
						(sy < -23'sd32768) ? 16'sh8000 : sy[15:0];
					vertex_index <= k_q[5:0];
					last_vertex <= (k_q + 9'd1 == job_q.sides);
					out_valid <= 1'b1;
					st_q <= B_OUT;
				end
				B_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					if (k_q + 9'd1 == job_q.sides) st_q <= B_IDLE;
					else begin
						// advance to the next vertex
						k_q <= k_q + 9'd1;
						acc_q <= acc_q + job_q.step;
						st_q <= B_LOAD;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == B_OUT) else $error("valid outside output state");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> k_q < job_q.sides) else $error("index beyond side count");
	a_it: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_MUL |-> 32'(it_q) == NSTEP) else $error("short rotation");
`endif
endmodule

>>> rtl/regular_polygon_vertex_generator_unit.sv
`timescale 1ns / 1ps
// Regular polygon vertex generator.
// Input channel (in_valid/in_ready): one request with radius, side count,
// centre and start angle. Output channel (out_valid/out_ready): one vertex
// item per side with its index and a last flag; a side count of zero gives
// no items, counts above MAX_SIDES are clamped.
// The front stage takes a request and divides 2^32 by the side count, one
// quotient bit a cycle, then hands the job through a one-entry queue; it
// takes the next request while the back stage is still busy.
// The back stage runs the CORDIC one iteration a cycle for each vertex in
// turn, then the radius multiply and the sum, so the time a polygon takes
// is bounded by the CORDIC loop.
// The vertex sits in an output register until taken; a stalled receiver
// stops the back stage, and the front stage stops once the queue is full.
// Reset clears both stages and the queue; no item is in flight afterwards.
module regular_polygon_vertex_generator_unit #(
	parameter int MAX_SIDES    = rpvg_pkg::MAX_SIDES_DEF,
	parameter int CORDIC_STEPS = rpvg_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] radius_len,
	input  logic [6:0]  side_count,
	input  logic signed [15:0] centre_x,
	input  logic signed [15:0] centre_y,
	input  logic [15:0] start_angle,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] vertex_x,
	output logic signed [15:0] vertex_y,
	output logic [5:0] vertex_index,
	output logic last_vertex
);
	import rpvg_pkg::*;
	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, qjob_q;
	logic full_q;

	rpvg_front #(.MAX_SIDES(MAX_SIDES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .radius_len, .side_count,
		.centre_x, .centre_y, .start_angle,
		.q_valid(f_valid), .q_ready(f_ready), .q_job(f_job));

	// one-entry job queue
	assign f_ready = !full_q;
	assign b_valid = full_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (f_valid && f_ready) full_q <= 1'b1;
		else if (b_valid && b_ready) full_q <= 1'b0;
	end
	always_ff @(posedge clk) if (f_valid && f_ready) qjob_q <= f_job;

	rpvg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .j_valid(b_valid), .j_ready(b_ready), .j_job(qjob_q),
		.out_valid, .out_ready, .vertex_x, .vertex_y, .vertex_index, .last_vertex);
endmodule

>>> test/tb_regular_polygon_vertex_generator_unit.sv
`timescale 1ns / 1ps
module tb_regular_polygon_vertex_generator_unit;
	import rpvg_pkg::*;

	localparam int MAX_SIDES    = MAX_SIDES_DEF;
	localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
	localparam int WATCHDOG     = 20000;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [5:0]         index;
		logic               last;
	} vertex_t;

	typedef struct {
		logic [15:0]        radius;
		logic [6:0]         sides;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [15:0]        start;
		bit                 typed;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] radius_len = '0;
	logic [6:0] side_count = '0;
	logic signed [15:0] centre_x = '0;
	logic signed [15:0] centre_y = '0;
	logic [15:0] start_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] vertex_x;
	logic signed [15:0] vertex_y;
	logic [5:0] vertex_index;
	logic last_vertex;

	vertex_t expected_vertices[$];
	request_t directed_rows[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	always #1 clk = ~clk;

	regular_polygon_vertex_generator_unit uut (.*);

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic void rotate_unit(logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, t;
		logic [31:0] r;
		bit flip;
		int n;
		x = 652032875;
		y = 0;
		flip = 1'b0;
		z = longint'(signed'(ang));
		if (z > 64'sh40000000 || z < -64'sh40000000) begin
			r = ang - 32'h80000000;
			z = longint'(signed'(r));
			flip = 1'b1;
		end
		n = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
		for (int i = 0; i < n; i++) begin
			if (z >= 0) begin
				t = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= longint'(atan_turn(i[4:0]));
			end else begin
				t = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += longint'(atan_turn(i[4:0]));
			end
			x = t;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	// append the vertices of one polygon to the expectation store
	function automatic void predict_polygon(request_t rq);
		int n;
		logic [31:0] step, accum;
		longint c, s, px, py;
		vertex_t v;
		n = (rq.sides > MAX_SIDES) ? MAX_SIDES : rq.sides;
		step = (n != 0) ? 32'((64'd1 << 32) / n) : 32'd0;
		accum = {rq.start, 16'd0};
		for (int k = 0; k < n; k++) begin
			rotate_unit({accum[31:16], 16'd0}, c, s);
			px = floor_shr(longint'(rq.radius) * c + (64'sd1 <<< 29), 30);
			py = floor_shr(longint'(rq.radius) * s + (64'sd1 <<< 29), 30);
			v.x = 16'(clamp16(px + longint'(rq.cx)));
			v.y = 16'(clamp16(py + longint'(rq.cy)));
			v.index = k[5:0];
			v.last = (k + 1 == n);
			if (rq.typed && k == 0 && (v.x !== rq.ex || v.y !== rq.ey)) begin
				mismatch_count++;
				$display("typed row disagrees: exp %0d,%0d pred %0d,%0d",
					rq.ex, rq.ey, v.x, v.y);
			end
			expected_vertices = {expected_vertices, v};
			accum += step;
		end
	endfunction

	function automatic request_t make_row(int r, int n, int x, int y, int a);
		request_t rq;
		rq.radius = r[15:0];
		rq.sides = n[6:0];
		rq.cx = x[15:0];
		rq.cy = y[15:0];
		rq.start = a[15:0];
		rq.typed = 1'b0;
		rq.ex = '0;
		rq.ey = '0;
		return rq;
	endfunction

	function automatic request_t typed_row(int r, int n, int x, int y, int a, int ex, int ey);
		request_t rq;
		rq = make_row(r, n, x, y, a);
		rq.typed = 1'b1;
		rq.ex = ex[15:0];
		rq.ey = ey[15:0];
		return rq;
	endfunction

	function automatic request_t random_row();
		request_t rq;
		int pick;
		pick = $urandom_range(0, 9);
		rq = make_row($urandom, $urandom_range(0, 8), $urandom, $urandom, $urandom);
		if (pick == 0) rq.sides = 7'($urandom_range(0, 127));
		else if (pick == 1) rq.sides = 7'($urandom_range(9, 64));
		if (pick == 2) rq.radius = 16'($urandom_range(0, 255));
		if (pick == 3) begin
			rq.cx = $urandom_range(0, 3) == 0 ? 16'sh7FF0 : 16'sh8010;
			rq.radius = 16'hFFFF;
		end
		return rq;
	endfunction

	task automatic send_request(request_t rq);
		radius_len <= rq.radius;
		side_count <= rq.sides;
		centre_x <= rq.cx;
		centre_y <= rq.cy;
		start_angle <= rq.start;
		in_valid <= 1'b1;
		predict_polygon(rq);
		// hold the item until the edge that accepts it
		@(posedge clk iff in_ready);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else case ($urandom_range(0, 7))
			0, 1: out_ready <= 1'b0;
			default: out_ready <= 1'b1;
		endcase
	end

	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected vertex x=%0d y=%0d idx=%0d",
						vertex_x, vertex_y, vertex_index);
			end else begin
				e = expected_vertices.pop_front();
				if (vertex_x !== e.x || vertex_y !== e.y
						|| vertex_index !== e.index || last_vertex !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("vertex mismatch: exp %0d,%0d,%0d,%0b got %0d,%0d,%0d,%0b",
							e.x, e.y, e.index, e.last,
							vertex_x, vertex_y, vertex_index, last_vertex);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		directed_rows = {directed_rows, typed_row(0, 3, 0, 0, 0, 0, 0)};
		directed_rows = {directed_rows,
			typed_row(0, 1, -32768, 32767, 65535, -32768, 32767)};
		directed_rows = {directed_rows, make_row(16, 4, 0, 0, 0)};
		directed_rows = {directed_rows, make_row(65535, 3, 32767, 32767, 0)};
		directed_rows = {directed_rows, make_row(65535, 4, -32768, -32768, 32768)};
		directed_rows = {directed_rows, make_row(160, 0, 5, 5, 0)};
		directed_rows = {directed_rows, make_row(160, 1, 0, 0, 16384)};
		directed_rows = {directed_rows, make_row(1600, 2, 0, 0, 16384)};
		directed_rows = {directed_rows, make_row(1600, 64, 100, -100, 12345)};
		directed_rows = {directed_rows, make_row(1600, 65, 0, 0, 0)};
		directed_rows = {directed_rows, make_row(43690, 127, 21845, -21846, 43690)};
		directed_rows = {directed_rows, make_row(21845, 5, -21846, 21845, 21845)};
		directed_rows = {directed_rows, make_row(65535, 7, 0, 0, 49152)};
		directed_rows = {directed_rows, make_row(1000, 6, 0, 0, 16385)};
		directed_rows = {directed_rows, make_row(1000, 3, 0, 0, 16383)};
		directed_rows = {directed_rows, make_row(1, 8, 0, 0, 32767)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i]);
			if (i % 3 == 2) drop_valid();
		end
		drop_valid();

		for (int i = 0; i < 270; i++) begin
			if (i == 150) begin
				// let every vertex drain before resuming
				in_valid <= 1'b0;
				while (expected_vertices.size() != 0) @(posedge clk);
			end
			send_request(random_row());
			if (!hold_off) random_gap();
		end
		in_valid <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (mismatch_count == 0 && expected_vertices.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
